@@ hdl/pgg_pkg.sv @@
package pgg_pkg;

  // palette and strip limits
  localparam int MAX_COLOURS = 10;
  localparam int MAX_PIXELS  = 1024;
  localparam int PAL_AW      = $clog2(MAX_COLOURS);

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_EFFECT_LENGTH = 2'd0;
  localparam logic [1:0] REG_EFFECT_STEPS  = 2'd1;
  localparam logic [1:0] REG_START_FAR     = 2'd2;
  localparam logic [1:0] REG_COLOUR_COUNT  = 2'd3;

  // front queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // pipelined divider: restoring, a few quotient bits per stage
  localparam int DIV_W               = 20;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = DIV_W / DIV_STEPS_PER_STAGE;

  // effective configuration, zero and out-of-range values already folded
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] steps;
    logic       far;
    logic [3:0] ncol;
  } cfg_t;

  // one request as it travels from front to back
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [23:0] rgb;
    logic [7:0]  step;
    logic [9:0]  pixel;
  } item_t;

  // divider working state: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [7:0]       rem;
    logic [DIV_W-1:0] sh;
  } div_state_t;

  // a few restoring division steps
  function automatic div_state_t div_stage(div_state_t s, logic [7:0] divisor);
    div_state_t r;
    logic [8:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
      t = {r.rem, r.sh[DIV_W-1]};
      if (t >= {1'b0, divisor}) begin
        r.rem = 8'(t - {1'b0, divisor});
        r.sh  = {r.sh[DIV_W-2:0], 1'b1};
      end else begin
        r.rem = t[7:0];
        r.sh  = {r.sh[DIV_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // (a * (256 - f) + b * f) >> 8, written as a + (b - a) * f / 256
  function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b,
                                               logic [7:0] f);
    logic signed [8:0]  diff;
    logic signed [17:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    acc  = $signed({2'b00, a, 8'h00}) + diff * $signed({1'b0, f});
    return acc[15:8];
  endfunction

endpackage

@@ hdl/pgg_ram.sv @@
module pgg_ram #(
  parameter int  WIDTH  = 24,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_data_a,
  output logic [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ hdl/pgg_div.sv @@
module pgg_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  pgg_pkg::item_t          in_item,
  input  logic [pgg_pkg::DIV_W-1:0] dividend,
  input  logic [7:0]              divisor,
  output logic                    out_valid,
  output pgg_pkg::item_t          out_item,
  output logic [pgg_pkg::DIV_W-1:0] quotient,
  output logic [7:0]              remainder
);
  import pgg_pkg::*;

  logic [DIV_STAGES-1:0] stage_valid;
  item_t                 stage_item [DIV_STAGES];
  div_state_t            stage_div  [DIV_STAGES];
  div_state_t            stage_div_next [DIV_STAGES];

  // each stage resolves a few quotient bits of the item it holds
  always_comb begin
    stage_div_next[0] = div_stage('{rem: 8'h00, sh: dividend}, divisor);
    for (int k = 1; k < DIV_STAGES; k++) begin
      stage_div_next[k] = div_stage(stage_div[k-1], divisor);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[DIV_STAGES-2:0], in_valid};
    end
  end

  // payload shift
  always_ff @(posedge clk) begin
    if (en) begin
      stage_item[0] <= in_item;
      for (int k = 1; k < DIV_STAGES; k++) begin
        stage_item[k] <= stage_item[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        stage_div[k] <= stage_div_next[k];
      end
    end
  end

  assign out_valid = stage_valid[DIV_STAGES-1];
  assign out_item  = stage_item[DIV_STAGES-1];
  assign quotient  = stage_div[DIV_STAGES-1].sh;
  assign remainder = stage_div[DIV_STAGES-1].rem;

endmodule

@@ hdl/pgg_front.sv @@
module pgg_front (
  input  logic           clk,
  input  logic           rst,
  input  pgg_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  pgg_pkg::item_t in_item,
  output logic           q_valid,
  output pgg_pkg::item_t q_item,
  input  logic           pop
);
  import pgg_pkg::*;

  item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              keep;
  logic              push;

  // classify: bad load slots, steps past the cycle and off-strip pixels are dropped
  always_comb begin
    if (in_item.kind == REQ_LOAD) begin
      keep = 32'(in_item.slot) < MAX_COLOURS;
    end else begin
      keep = (in_item.step <= cfg.steps) && (32'(in_item.pixel) < MAX_PIXELS);
    end
  end

  assign in_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = count != '0;
  assign q_item   = queue[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

@@ hdl/pgg_back.sv @@
module pgg_back (
  input  logic           clk,
  input  logic           rst,
  input  pgg_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  pgg_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [9:0]     out_pixel,
  output logic [7:0]     red_level,
  output logic [7:0]     green_level,
  output logic [7:0]     blue_level
);
  import pgg_pkg::*;

  logic adv;

  logic        s0_valid;
  item_t       s0_item;
  logic [17:0] s0_prod;

  logic             d1_valid;
  item_t            d1_item;
  logic [DIV_W-1:0] d1_quo;
  logic [7:0]       d1_rem;

  logic        s1_valid;
  item_t       s1_item;
  logic [18:0] s1_x;
  logic [17:0] q;

  logic             d2_valid;
  item_t            d2_item;
  logic [DIV_W-1:0] d2_quo;
  logic [7:0]       d2_rem;

  logic        s2_valid;
  item_t       s2_item;
  logic [11:0] s2_v;

  logic             d3_valid;
  item_t            d3_item;
  logic [DIV_W-1:0] d3_quo;
  logic [7:0]       d3_rem;

  logic        s3_valid;
  item_t       s3_item;
  logic [7:0]  s3_f;

  logic [3:0]        seg;
  logic [3:0]        nxt;
  logic              pal_we;
  logic [23:0]       pal_a;
  logic [23:0]       pal_b;

  // whole pipeline moves unless a finished pixel is waiting
  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  // offset numerator: pixel * steps
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= q_item;
      s0_prod <= 18'(q_item.pixel) * 18'(cfg.steps);
    end
  end

  // offset along the strip: q = pixel * steps / length
  pgg_div u_div_offset (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s0_valid),
    .in_item  (s0_item),
    .dividend (DIV_W'(s0_prod)),
    .divisor  (cfg.len),
    .out_valid(d1_valid),
    .out_item (d1_item),
    .quotient (d1_quo),
    .remainder(d1_rem)
  );

  assign q = d1_quo[17:0];

  // raw position: step + q, or |step - q| from the far side
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= d1_item;
      if (!cfg.far) begin
        s1_x <= 19'(d1_item.step) + 19'(q);
      end else if (18'(d1_item.step) >= q) begin
        s1_x <= 19'(18'(d1_item.step) - q);
      end else begin
        s1_x <= 19'(q - 18'(d1_item.step));
      end
    end
  end

  // position modulo steps
  pgg_div u_div_wrap (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s1_valid),
    .in_item  (s1_item),
    .dividend (DIV_W'(s1_x)),
    .divisor  (cfg.steps),
    .out_valid(d2_valid),
    .out_item (d2_item),
    .quotient (d2_quo),
    .remainder(d2_rem)
  );

  // scale to palette: pm * colours; far side maps r to (steps - r) mod steps
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= d2_item;
      if (cfg.far && d2_rem != 8'h00) begin
        s2_v <= 12'(cfg.steps - d2_rem) * 12'(cfg.ncol);
      end else begin
        s2_v <= 12'(d2_rem) * 12'(cfg.ncol);
      end
    end
  end

  // segment and 8-bit fraction in one quotient: pm * n * 256 / steps
  pgg_div u_div_segment (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s2_valid),
    .in_item  (s2_item),
    .dividend (DIV_W'({s2_v, 8'h00})),
    .divisor  (cfg.steps),
    .out_valid(d3_valid),
    .out_item (d3_item),
    .quotient (d3_quo),
    .remainder(d3_rem)
  );

  // neighbor entry wraps to zero after the last colour in use
  always_comb begin
    seg = d3_quo[11:8];
    if (({1'b0, seg} + 5'd1) >= {1'b0, cfg.ncol}) begin
      nxt = 4'd0;
    end else begin
      nxt = seg + 4'd1;
    end
  end

  // loads write the palette at the same stage where renders read it
  assign pal_we = adv && d3_valid && (d3_item.kind == REQ_LOAD)
                  && (32'(d3_item.slot) < MAX_COLOURS);

  pgg_ram #(
    .WIDTH(24),
    .DEPTH(MAX_COLOURS)
  ) u_palette (
    .clk      (clk),
    .wr_en    (pal_we),
    .wr_addr  (d3_item.slot[PAL_AW-1:0]),
    .wr_data  (d3_item.rgb),
    .rd_en    (adv),
    .rd_addr_a(seg[PAL_AW-1:0]),
    .rd_addr_b(nxt[PAL_AW-1:0]),
    .rd_data_a(pal_a),
    .rd_data_b(pal_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item <= d3_item;
      s3_f    <= d3_quo[7:0];
    end
  end

  // blend and output register; only renders produce a pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid && (s3_item.kind == REQ_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel   <= s3_item.pixel;
      red_level   <= blend_channel(pal_a[23:16], pal_b[23:16], s3_f);
      green_level <= blend_channel(pal_a[15:8], pal_b[15:8], s3_f);
      blue_level  <= blend_channel(pal_a[7:0], pal_b[7:0], s3_f);
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (s0_valid == $past(s0_valid)) && (s1_valid == $past(s1_valid))
             && (s3_valid == $past(s3_valid)))
    else $error("pipeline moved during stall");

  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    pop |-> adv && q_valid)
    else $error("queue popped without room");

  a_load_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid && s3_item.kind == REQ_LOAD) |=> !out_valid)
    else $error("load produced a pixel");
`endif

endmodule

@@ hdl/palette_gradient_pixel_generator.sv @@
// Palette gradient pixel generator.
// Input channel (in_valid/in_ready): req_type 0 loads palette_rgb into
// palette_slot; req_type 1 renders pixel_pos at anim_step. Loads and renders
// that name a bad slot or a step past effect_steps are taken and dropped.
// Output channel (out_valid/out_ready): one blended colour per render, in
// order, with the pixel index echoed on out_pixel.
// Configuration: cfg_we writes cfg_data to register cfg_index (effect_length,
// effect_steps, start_far, colour_count); write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. Path of a render:
// the front queue, three 10-stage dividers (strip offset, position wrap,
// segment/fraction), then palette read and blend stages.
// Stall: a held transfer on the output freezes the whole back pipeline; the
// 4-entry front queue keeps taking items until it fills, then drops in_ready.
// Reset (synchronous, rst high) empties queue and pipeline and restores
// length 1, steps 1, near side, one colour. Palette contents are undefined
// until loaded.
module palette_gradient_pixel_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [3:0]  palette_slot,
  input  logic [23:0] palette_rgb,
  input  logic [7:0]  anim_step,
  input  logic [9:0]  pixel_pos,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_pixel,
  output logic [7:0]  red_level,
  output logic [7:0]  green_level,
  output logic [7:0]  blue_level
);
  import pgg_pkg::*;

  logic [7:0] effect_length;
  logic [7:0] effect_steps;
  logic       start_far;
  logic [3:0] colour_count;
  cfg_t       cfg;
  item_t      in_item;
  logic       q_valid;
  item_t      q_item;
  logic       pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_length <= 8'd1;
      effect_steps  <= 8'd1;
      start_far     <= 1'b0;
      colour_count  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EFFECT_LENGTH: effect_length <= cfg_data;
        REG_EFFECT_STEPS:  effect_steps  <= cfg_data;
        REG_START_FAR:     start_far     <= cfg_data[0];
        REG_COLOUR_COUNT:  colour_count  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // fold zero and oversize settings into usable values
  always_comb begin
    cfg.len   = (effect_length == 8'd0) ? 8'd1 : effect_length;
    cfg.steps = (effect_steps == 8'd0) ? 8'd1 : effect_steps;
    cfg.far   = start_far;
    if (colour_count == 4'd0) begin
      cfg.ncol = 4'd1;
    end else if (32'(colour_count) > MAX_COLOURS) begin
      cfg.ncol = 4'(MAX_COLOURS);
    end else begin
      cfg.ncol = colour_count;
    end
  end

  assign in_item = '{kind: req_type, slot: palette_slot, rgb: palette_rgb,
                     step: anim_step, pixel: pixel_pos};

  pgg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop)
  );

  pgg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .red_level  (red_level),
    .green_level(green_level),
    .blue_level (blue_level)
  );

endmodule

@@ tb/palette_gradient_pixel_generator_test.sv @@
module palette_gradient_pixel_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pgg_pkg::*;

  // cycles to let dropped items drain before touching registers
  localparam int DRAIN_CYCLES = 50;
  // length of the long output hold-off
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 112;

  typedef struct packed {
    logic [9:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  // palette/config mirror, predicts each render and checks the output stream
  class gradient_scoreboard;
    logic [23:0] palette [MAX_COLOURS];
    logic [7:0]  len_reg;
    logic [7:0]  steps_reg;
    logic        far_reg;
    logic [3:0]  ncol_reg;
    colour_t     expected_colours [$];
    int          errors;
    int          checked;
    int          loads;
    int          dropped;

    function new();
      len_reg   = 8'd1;
      steps_reg = 8'd1;
      far_reg   = 1'b0;
      ncol_reg  = 4'd1;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_EFFECT_LENGTH: len_reg = val;
        REG_EFFECT_STEPS:  steps_reg = val;
        REG_START_FAR:     far_reg = val[0];
        REG_COLOUR_COUNT:  ncol_reg = val[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned effective_steps();
      return (steps_reg == 0) ? 1 : steps_reg;
    endfunction

    function logic [7:0] mix(int unsigned a, int unsigned b, int unsigned frac);
      int unsigned acc;
      acc = (a * (256 - frac) + b * frac) >> 8;
      return 8'(acc);
    endfunction

    // one accepted input transfer
    function void note_request(logic kind, logic [3:0] slot, logic [23:0] rgb,
                               logic [7:0] step, logic [9:0] pixel);
      int unsigned len, steps, ncol, stp, pix, q, pos, diff, pm, seg, nxt, frac;
      logic [23:0] c1, c2;
      colour_t c;
      if (kind == REQ_LOAD) begin
        loads++;
        if (slot < MAX_COLOURS) palette[slot] = rgb;
        return;
      end
      len   = (len_reg == 0) ? 1 : len_reg;
      steps = effective_steps();
      ncol  = (ncol_reg == 0) ? 1 : (ncol_reg > MAX_COLOURS) ? MAX_COLOURS : ncol_reg;
      stp   = step;
      pix   = pixel;
      // step past the cycle length is dropped
      if (stp > steps || pix >= MAX_PIXELS) begin
        dropped++;
        return;
      end
      // position along the gradient
      q = (pix * steps) / len;
      if (!far_reg) begin
        pos = stp + q;
      end else begin
        diff = (stp >= q) ? stp - q : q - stp;
        pos  = steps - (diff % steps);
      end
      pm = pos % steps;
      // segment, fraction and blend with the next entry
      seg  = (pm * ncol) / steps;
      frac = (((pm * ncol) % steps) * 256) / steps;
      nxt  = (seg + 1 >= ncol) ? 0 : seg + 1;
      c1 = palette[seg];
      c2 = palette[nxt];
      c.pixel = pixel;
      c.red   = mix(c1[23:16], c2[23:16], frac);
      c.green = mix(c1[15:8], c2[15:8], frac);
      c.blue  = mix(c1[7:0], c2[7:0], frac);
      expected_colours.push_back(c);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
                 act_val);
      end
    endfunction

    // one accepted output transfer
    function void check_pixel(colour_t got);
      colour_t exp_c;
      if (expected_colours.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, got pixel %0d rgb %06h",
                 $time, got.pixel, {got.red, got.green, got.blue});
        return;
      end
      exp_c = expected_colours.pop_front();
      checked++;
      compare_field("out_pixel", exp_c.pixel, got.pixel);
      compare_field("red_level", exp_c.red, got.red);
      compare_field("green_level", exp_c.green, got.green);
      compare_field("blue_level", exp_c.blue, got.blue);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [3:0]  palette_slot;
  logic [23:0] palette_rgb;
  logic [7:0]  anim_step;
  logic [9:0]  pixel_pos;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_pixel;
  logic [7:0]  red_level;
  logic [7:0]  green_level;
  logic [7:0]  blue_level;

  gradient_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int settings = 0;

  palette_gradient_pixel_generator DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .palette_slot(palette_slot),
    .palette_rgb(palette_rgb),
    .anim_step(anim_step),
    .pixel_pos(pixel_pos),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel(out_pixel),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // give up after a generous time
  initial begin
    #1_000_000;
    $display("palette_gradient_pixel_generator test failed");
    $finish;
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    colour_t got;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.pixel = out_pixel;
        got.red   = red_level;
        got.green = green_level;
        got.blue  = blue_level;
        sb.check_pixel(got);
      end
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one input transfer, with random gaps ahead of it
  task automatic send_item(input logic kind, input logic [3:0] slot,
                           input logic [23:0] rgb, input logic [7:0] step,
                           input logic [9:0] pixel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    palette_slot <= slot;
    palette_rgb  <= rgb;
    anim_step    <= step;
    pixel_pos    <= pixel;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, slot, rgb, step, pixel);
  endtask

  task automatic load_entry(input logic [3:0] slot, input logic [23:0] rgb);
    send_item(REQ_LOAD, slot, rgb, 8'($urandom), 10'($urandom));
  endtask

  task automatic render(input logic [7:0] step, input logic [9:0] pixel);
    send_item(REQ_RENDER, 4'($urandom), 24'($urandom), step, pixel);
  endtask

  // register write, enable left high for the next one
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] len, input logic [7:0] steps,
                            input logic far, input logic [3:0] ncol);
    write_reg(REG_EFFECT_LENGTH, len);
    write_reg(REG_EFFECT_STEPS, steps);
    write_reg(REG_START_FAR, {7'd0, far});
    write_reg(REG_COLOUR_COUNT, {4'd0, ncol});
    cfg_we <= 1'b0;
    settings++;
  endtask

  // stop offering, wait for all colours, then let dropped items drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_colours.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly in-range renders, some loads and some steps past the cycle
  task automatic random_item();
    int unsigned pick, s, pix_pick;
    logic [9:0] pixel;
    pick = $urandom_range(99);
    s = sb.effective_steps();
    pix_pick = $urandom_range(99);
    pixel = (pix_pick < 5) ? 10'd0 : (pix_pick < 10) ? 10'd1023 : 10'($urandom);
    if (pick < 10) begin
      load_entry(4'($urandom_range(15)), 24'($urandom));
    end else if (pick < 18 && s < 255) begin
      render(8'($urandom_range(255, s + 1)), pixel);
    end else begin
      render(8'($urandom_range(s, 0)), pixel);
    end
  endtask

  initial begin
    logic [7:0] len, steps;
    logic far;
    logic [3:0] ncol;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_EFFECT_LENGTH;
    cfg_data     <= 8'd0;
    in_valid     <= 1'b0;
    req_type     <= REQ_LOAD;
    palette_slot <= 4'd0;
    palette_rgb  <= 24'd0;
    anim_step    <= 8'd0;
    pixel_pos    <= 10'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every palette entry before any render reads one
    load_entry(4'd0, 24'h000000);
    load_entry(4'd1, 24'hFFFFFF);
    load_entry(4'd2, 24'hFF0000);
    load_entry(4'd3, 24'h00FF00);
    load_entry(4'd4, 24'h0000FF);
    load_entry(4'd5, 24'h123456);
    load_entry(4'd6, 24'hABCDEF);
    load_entry(4'd7, 24'h808080);
    load_entry(4'd8, 24'h7F7F7F);
    load_entry(4'd9, 24'h010203);
    // slots past the palette are ignored
    load_entry(4'd10, 24'hFFFFFF);
    load_entry(4'd15, 24'h55AA55);
    // reset settings: one step, one colour
    render(8'd0, 10'd0);
    render(8'd1, 10'd1023);
    render(8'd2, 10'd7);

    wait_idle();
    set_config(8'd7, 8'd20, 1'b0, 4'd10);
    render(8'd0, 10'd0);
    render(8'd20, 10'd1023);
    render(8'd21, 10'd5);
    render(8'd255, 10'd3);
    render(8'd10, 10'd3);

    wait_idle();
    set_config(8'd200, 8'd255, 1'b1, 4'd10);
    render(8'd255, 10'd1023);
    render(8'd0, 10'd0);
    render(8'd128, 10'd512);

    // random phases, each under its own settings; groups of four phases share an idling mode
    for (int p = 0; p < PHASES; p++) begin
      case (p / 4)
        0: begin send_idle_pct = 31; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: begin len = 8'd0;   steps = 8'd0;   far = 1'b0; ncol = 4'd0;  end
        1: begin len = 8'd255; steps = 8'd255; far = 1'b1; ncol = 4'd10; end
        2: begin len = 8'd1;   steps = 8'd255; far = 1'b0; ncol = 4'd15; end
        3: begin len = 8'd255; steps = 8'd1;   far = 1'b1; ncol = 4'd1;  end
        4: begin len = 8'd37;  steps = 8'd100; far = 1'b1; ncol = 4'd11; end
        default: begin
          len   = 8'($urandom_range(255));
          steps = 8'($urandom_range(255));
          far   = 1'($urandom);
          ncol  = 4'($urandom_range(15));
        end
      endcase
      wait_idle();
      set_config(len, steps, far, ncol);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long output hold-off while inputs keep coming
        if (p == 2 && i == 30) hold_request = 1'b1;
        random_item();
      end
    end

    wait_idle();
    $display("checked %0d colours over %0d register settings", sb.checked, settings);
    $display("%0d palette loads, %0d renders dropped for a step past the cycle",
             sb.loads, sb.dropped);
    if (sb.errors == 0) begin
      $display("palette_gradient_pixel_generator test passed");
    end else begin
      $display("palette_gradient_pixel_generator test failed");
    end
    $finish;
  end

endmodule
